// ----- sv/sbpd_pkg.sv -----
// Shared types and constants for the six-button pad poll decoder.
`default_nettype none

package sbpd_pkg;

	localparam int unsigned LINE_W   = 6;
	localparam int unsigned BUTTON_W = 13;
	localparam int unsigned SKIP_W   = 2;

	// Pad line bit positions
	localparam int unsigned LINE_D0 = 0;
	localparam int unsigned LINE_D1 = 1;
	localparam int unsigned LINE_D2 = 2;
	localparam int unsigned LINE_D3 = 3;
	localparam int unsigned LINE_TL = 4;
	localparam int unsigned LINE_TR = 5;

	// Button word bit positions
	localparam int unsigned BTN_UP    = 0;
	localparam int unsigned BTN_DOWN  = 1;
	localparam int unsigned BTN_LEFT  = 2;
	localparam int unsigned BTN_RIGHT = 3;
	localparam int unsigned BTN_A     = 4;
	localparam int unsigned BTN_B     = 5;
	localparam int unsigned BTN_C     = 6;
	localparam int unsigned BTN_START = 7;
	localparam int unsigned BTN_X     = 8;
	localparam int unsigned BTN_Y     = 9;
	localparam int unsigned BTN_Z     = 10;
	localparam int unsigned BTN_MODE  = 11;
	localparam int unsigned BTN_HOME  = 12;

	// Ticks skipped after the six-button phase; Home is read on the first
	localparam logic [SKIP_W-1:0] SKIP_AFTER_SIX = 2'd2;

	typedef logic [LINE_W-1:0]   lines_t;
	typedef logic [BUTTON_W-1:0] buttons_t;

	typedef struct packed {
		logic               select_high;
		logic               pad_connected;
		logic               six_pending;
		logic [SKIP_W-1:0]  skip_count;
		buttons_t           button_word;
	} poll_state_t;

	localparam poll_state_t POLL_RESET = '{
		select_high:   1'b1,
		pad_connected: 1'b0,
		six_pending:   1'b0,
		skip_count:    '0,
		button_word:   '0
	};

endpackage

`default_nettype wire

// ----- sv/sbpd_if.sv -----
// Valid/ready channel interfaces for pad samples and decoded button reports.
`default_nettype none

interface sbpd_sample_if;
	import sbpd_pkg::*;

	logic   valid;
	logic   ready;
	lines_t pad_lines;

	modport source (output valid, output pad_lines, input ready);
	modport sink (input valid, input pad_lines, output ready);
endinterface

interface sbpd_report_if;
	import sbpd_pkg::*;

	logic     valid;
	logic     ready;
	buttons_t buttons;
	logic     select_level;
	logic     pad_present;

	modport source (output valid, output buttons, output select_level, output pad_present,
		input ready);
	modport sink (input valid, input buttons, input select_level, input pad_present,
		output ready);
endinterface

`default_nettype wire

// ----- sv/sbpd_decode.sv -----
// Next-state decode of one poll tick from the current state and sampled lines.
`default_nettype none

module sbpd_decode (
	input  var sbpd_pkg::poll_state_t cur,
	input  var sbpd_pkg::lines_t      lines,
	output sbpd_pkg::poll_state_t     nxt
);
	import sbpd_pkg::*;

	lines_t pressed;

	// Lines are active low
	assign pressed = ~lines;

	always_comb begin
		nxt             = cur;
		nxt.select_high = !cur.select_high;

		if (cur.skip_count != '0) begin
			// Skip tick: only Home is read, on the first one
			if (cur.skip_count == SKIP_AFTER_SIX) begin
				nxt.button_word[BTN_HOME] = pressed[LINE_D0];
			end
			nxt.skip_count = cur.skip_count - 2'd1;
		end else if (nxt.select_high) begin
			if (cur.pad_connected) begin
				if (cur.six_pending) begin
					// Extra button phase
					nxt.button_word[BTN_Z]    = pressed[LINE_D0];
					nxt.button_word[BTN_Y]    = pressed[LINE_D1];
					nxt.button_word[BTN_X]    = pressed[LINE_D2];
					nxt.button_word[BTN_MODE] = pressed[LINE_D3];
					nxt.six_pending           = 1'b0;
					nxt.skip_count            = SKIP_AFTER_SIX;
				end else begin
					nxt.button_word[BTN_UP]    = pressed[LINE_D0];
					nxt.button_word[BTN_DOWN]  = pressed[LINE_D1];
					nxt.button_word[BTN_LEFT]  = pressed[LINE_D2];
					nxt.button_word[BTN_RIGHT] = pressed[LINE_D3];
					nxt.button_word[BTN_B]     = pressed[LINE_TL];
					nxt.button_word[BTN_C]     = pressed[LINE_TR];
				end
			end else begin
				// Two-button fallback: clear the word first
				nxt.button_word            = '0;
				nxt.button_word[BTN_UP]    = pressed[LINE_D0];
				nxt.button_word[BTN_DOWN]  = pressed[LINE_D1];
				nxt.button_word[BTN_LEFT]  = pressed[LINE_D2];
				nxt.button_word[BTN_RIGHT] = pressed[LINE_D3];
				nxt.button_word[BTN_A]     = pressed[LINE_TL];
				nxt.button_word[BTN_B]     = pressed[LINE_TR];
			end
		end else begin
			// Low phase: detect pad and six-button phase, and read A/Start when no six-button phase
			nxt.pad_connected = pressed[LINE_D2] & pressed[LINE_D3];
			nxt.six_pending   = pressed[LINE_D0] & pressed[LINE_D1];
			if (nxt.pad_connected && !nxt.six_pending) begin
				nxt.button_word[BTN_A]     = pressed[LINE_TL];
				nxt.button_word[BTN_START] = pressed[LINE_TR];
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/six_button_pad_poll_decoder.sv -----
// Top level of the six-button pad poll decoder.
// One sample transaction is taken every clock while the report side is ready, and each
// gives exactly one report transaction: the sample is held in an input register, and
// the decode (a few gates of flag and bit updates) runs from that register into the
// poll state and the result register. Throughput is one transaction per clock while
// the report side is ready; a stalled report holds the result register, then the
// input register, and then holds off the sample side. The select level reported with
// each result is the one that the pad should be driven with for that sample; the first
// sample after reset is taken at select low. One instance serves one pad port.
`default_nettype none

module six_button_pad_poll_decoder (
	input  wire            clk,
	input  wire            arst_n,
	sbpd_sample_if.sink    sample,
	sbpd_report_if.source  report
);
	import sbpd_pkg::*;

	logic        valid_s1;
	lines_t      lines_s1;
	logic        advance;
	poll_state_t state_q;
	poll_state_t state_next;
	logic        out_valid_q;
	buttons_t    buttons_q;
	logic        select_q;
	logic        present_q;

	// Move the input register into the result register when it is free
	assign advance      = valid_s1 && (!out_valid_q || report.ready);
	assign sample.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			lines_s1 <= sample.pad_lines;
		end
	end

	sbpd_decode u_decode (
		.cur   (state_q),
		.lines (lines_s1),
		.nxt   (state_next)
	);

	// Poll state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= POLL_RESET;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			buttons_q <= state_next.button_word;
			select_q  <= state_next.select_high;
			present_q <= state_next.pad_connected;
		end
	end

	assign report.valid        = out_valid_q;
	assign report.buttons      = buttons_q;
	assign report.select_level = select_q;
	assign report.pad_present  = present_q;

	// Skip count only ever starts at two
	assert property (@(posedge clk) disable iff (!arst_n) state_q.skip_count != 2'd3)
		else $error("skip count reached three");

	// Skipping follows a six-button phase of a present pad, pending already cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.skip_count != '0) |-> (state_q.pad_connected && !state_q.six_pending))
		else $error("skip active with pad absent or six-button phase pending");

	// Each decoded tick toggles the select level
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (state_q.select_high != $past(state_q.select_high)))
		else $error("select level did not toggle on a decoded tick");

	// Reported select level follows the poll state
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (select_q == state_q.select_high))
		else $error("reported select level differs from poll state");

endmodule

`default_nettype wire

// ----- test/six_button_pad_poll_decoder_tb.sv -----
// Regression bench for the six-button pad poll decoder: directed frames, then random pad traffic.
`default_nettype none

module six_button_pad_poll_decoder_tb;
	import sbpd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_SAMPLES = 1930;
	localparam int unsigned IDLE_PERCENT   = 24;
	localparam int unsigned DRAIN_CYCLES   = 10;

	typedef struct packed {
		buttons_t buttons;
		logic     select_level;
		logic     pad_present;
	} pad_report_t;

	logic clk = 1'b0;
	logic arst_n;

	sbpd_sample_if sample_ch ();
	sbpd_report_if report_ch ();

	six_button_pad_poll_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch.sink),
		.report (report_ch.source)
	);

	// Predicted poll state and the reports still owed by the block
	poll_state_t pad_state = POLL_RESET;
	pad_report_t expected_reports[$];

	int unsigned samples_sent    = 0;
	int unsigned reports_checked = 0;
	int unsigned mismatch_count  = 0;
	int unsigned stall_cycles    = 0;
	bit          src_idle_en     = 1'b1;
	bit          sink_idle_en    = 1'b1;

	always #1 clk = ~clk;

	// Advance the predicted poll state by one tick and give the report it produces
	function automatic pad_report_t predict_report(lines_t lines);
		lines_t      pressed;
		pad_report_t rep;
		pressed = ~lines;
		pad_state.select_high = ~pad_state.select_high;
		if (pad_state.skip_count != '0) begin
			// Skipped tick: only Home is read, on the first one
			if (pad_state.skip_count == SKIP_AFTER_SIX)
				pad_state.button_word[BTN_HOME] = pressed[LINE_D0];
			pad_state.skip_count = pad_state.skip_count - 2'd1;
		end else if (pad_state.select_high) begin
			if (pad_state.pad_connected) begin
				if (pad_state.six_pending) begin
					pad_state.button_word[BTN_Z]    = pressed[LINE_D0];
					pad_state.button_word[BTN_Y]    = pressed[LINE_D1];
					pad_state.button_word[BTN_X]    = pressed[LINE_D2];
					pad_state.button_word[BTN_MODE] = pressed[LINE_D3];
					pad_state.six_pending = 1'b0;
					pad_state.skip_count  = SKIP_AFTER_SIX;
				end else begin
					pad_state.button_word[BTN_UP]    = pressed[LINE_D0];
					pad_state.button_word[BTN_DOWN]  = pressed[LINE_D1];
					pad_state.button_word[BTN_LEFT]  = pressed[LINE_D2];
					pad_state.button_word[BTN_RIGHT] = pressed[LINE_D3];
					pad_state.button_word[BTN_B]     = pressed[LINE_TL];
					pad_state.button_word[BTN_C]     = pressed[LINE_TR];
				end
			end else begin
				// Two-button fallback starts from a clear word
				pad_state.button_word = '0;
				pad_state.button_word[BTN_UP]    = pressed[LINE_D0];
				pad_state.button_word[BTN_DOWN]  = pressed[LINE_D1];
				pad_state.button_word[BTN_LEFT]  = pressed[LINE_D2];
				pad_state.button_word[BTN_RIGHT] = pressed[LINE_D3];
				pad_state.button_word[BTN_A]     = pressed[LINE_TL];
				pad_state.button_word[BTN_B]     = pressed[LINE_TR];
			end
		end else begin
			pad_state.pad_connected = pressed[LINE_D2] & pressed[LINE_D3];
			pad_state.six_pending   = pressed[LINE_D0] & pressed[LINE_D1];
			if (pad_state.pad_connected && !pad_state.six_pending) begin
				pad_state.button_word[BTN_A]     = pressed[LINE_TL];
				pad_state.button_word[BTN_START] = pressed[LINE_TR];
			end
		end
		rep.buttons      = pad_state.button_word;
		rep.select_level = pad_state.select_high;
		rep.pad_present  = pad_state.pad_connected;
		return rep;
	endfunction

	// Predict on each sample transaction, check each report transaction
	always @(posedge clk) begin : report_check
		pad_report_t exp_rep;
		if (sample_ch.valid && sample_ch.ready)
			expected_reports.push_back(predict_report(sample_ch.pad_lines));
		if (report_ch.valid && report_ch.ready) begin
			if (expected_reports.size() == 0) begin
				$display("%0t: unexpected report, expected none, got buttons %h sel %b pad %b",
					$time, report_ch.buttons, report_ch.select_level, report_ch.pad_present);
				mismatch_count++;
			end else begin
				exp_rep = expected_reports.pop_front();
				if (report_ch.buttons !== exp_rep.buttons) begin
					$display("%0t: report %0d buttons expected %h got %h", $time,
						reports_checked, exp_rep.buttons, report_ch.buttons);
					mismatch_count++;
				end
				if (report_ch.select_level !== exp_rep.select_level) begin
					$display("%0t: report %0d select_level expected %b got %b", $time,
						reports_checked, exp_rep.select_level, report_ch.select_level);
					mismatch_count++;
				end
				if (report_ch.pad_present !== exp_rep.pad_present) begin
					$display("%0t: report %0d pad_present expected %b got %b", $time,
						reports_checked, exp_rep.pad_present, report_ch.pad_present);
					mismatch_count++;
				end
			end
			reports_checked++;
		end
	end

	// Drive ready: hold off for a requested stretch, otherwise idle at random
	initial begin
		report_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_cycles != 0) begin
				report_ch.ready <= 1'b0;
				stall_cycles--;
			end else begin
				report_ch.ready <= !sink_idle_en || ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	// Offer one pad sample and hold it until the transaction completes
	task automatic send_sample(input lines_t lines);
		@(negedge clk);
		while (src_idle_en && $urandom_range(99) < IDLE_PERCENT) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid     <= 1'b1;
		sample_ch.pad_lines <= lines;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		samples_sent++;
	endtask

	// Hold the sender until every owed report has arrived
	task automatic wait_drained();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (expected_reports.size() != 0)
			@(negedge clk);
	endtask

	// No pad: fallback decode, and six-button pending left set without a pad
	task automatic test_two_button_fallback();
		send_sample(6'h3F);
		send_sample(6'h00);
		send_sample(6'h3F);
		send_sample(6'h3F);
		send_sample(6'h3C);
		send_sample(6'h2A);
		send_sample(6'h3F);
	endtask

	// Three-button pad: A/Start at select low, directions/B/C at select high
	task automatic test_three_button_pad();
		send_sample(6'h03);
		send_sample(6'h00);
		send_sample(6'h33);
		send_sample(6'h3F);
	endtask

	// Six-button pad: X/Y/Z/Mode, Home on the first skipped tick, then fall back
	task automatic test_six_button_pad();
		send_sample(6'h30);
		send_sample(6'h30);
		send_sample(6'h3E);
		send_sample(6'h00);
		send_sample(6'h00);
		send_sample(6'h3F);
		send_sample(6'h3F);
		send_sample(6'h00);
		send_sample(6'h3F);
		send_sample(6'h15);
	endtask

	// Mostly well-formed pad frames with random content, the rest noise
	task automatic test_random_frames();
		lines_t      lines;
		int unsigned kind;
		for (int unsigned i = 0; i < RANDOM_SAMPLES; i++) begin
			// Fill the block against a long report hold-off
			if (i == 500)
				stall_cycles = 120;
			// Pause the sender until all reports are back
			if (i == 1000)
				wait_drained();
			src_idle_en  = !(i >= 1200 && i < 1500);
			sink_idle_en = src_idle_en;
			lines = lines_t'($urandom);
			if (samples_sent[0] == 1'b0) begin
				kind = $urandom_range(99);
				if (kind < 45) begin
					lines[LINE_D3:LINE_D0] = 4'b0000;
				end else if (kind < 80) begin
					lines[LINE_D3:LINE_D2] = 2'b00;
					lines[LINE_D1:LINE_D0] = 2'($urandom_range(3, 1));
				end
			end
			send_sample(lines);
		end
	endtask

	initial begin
		arst_n              = 1'b0;
		sample_ch.valid     = 1'b0;
		sample_ch.pad_lines = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_two_button_fallback();
		test_three_button_pad();
		test_six_button_pad();
		test_random_frames();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d pad samples: fallback, three- and six-button frames, noise,",
			samples_sent);
		$display("random idling, a long report hold-off and a drained pause; %0d reports checked.",
			reports_checked);
		if (mismatch_count == 0 && expected_reports.size() == 0) begin
			$display("six_button_pad_poll_decoder regression: pass");
		end else begin
			$display("six_button_pad_poll_decoder regression: fail");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#200000;
		$display("%0t: timeout with %0d reports outstanding", $time, expected_reports.size());
		$display("six_button_pad_poll_decoder regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
